// ===== hdl/pwbs_pkg.sv =====
// Package for the waveform bar scaler: sizes, reset values, item and config types, FSM states.
`timescale 1ns / 1ps
package pwbs_pkg;

    localparam int SAMPLE_BITS    = 18;
    localparam int BYTES_BITS     = 24;
    localparam int TRACK_BITS     = SAMPLE_BITS + 1;
    localparam int MARGIN_BITS    = 12;
    localparam int DIVISOR_BITS   = 8;
    localparam int BAR_BITS       = 6;
    localparam int STROBE_BITS    = 4;
    localparam int BLOCK_SAMPLES  = 100;
    localparam int POS_BITS       = $clog2(BLOCK_SAMPLES);
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = SAMPLE_BITS;
    localparam int DIV_CNT_BITS   = $clog2(TRACK_BITS + 1);

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MASK = {SAMPLE_BITS{1'b1}};

    // register indexes on the config port
    localparam logic [CFG_INDEX_BITS-1:0] REG_VALID_LOW       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VALID_HIGH      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_MARGIN     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_DIVISOR   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BAR_LIMIT       = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UPDATE_INTERVAL = 3'd5;

    // register reset values
    localparam logic [SAMPLE_BITS-1:0]  VALID_LOW_RST       = SAMPLE_BITS'(86016);
    localparam logic [SAMPLE_BITS-1:0]  VALID_HIGH_RST      = SAMPLE_BITS'(196608);
    localparam logic [MARGIN_BITS-1:0]  PEAK_MARGIN_RST     = MARGIN_BITS'(256);
    localparam logic [DIVISOR_BITS-1:0] RANGE_DIVISOR_RST   = DIVISOR_BITS'(14);
    localparam logic [BAR_BITS-1:0]     BAR_LIMIT_RST       = BAR_BITS'(16);
    localparam logic [STROBE_BITS-1:0]  UPDATE_INTERVAL_RST = STROBE_BITS'(4);

    typedef struct packed {
        logic [BYTES_BITS-1:0] red_bytes;
        logic [BYTES_BITS-1:0] ir_bytes;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] red_sample;
        logic [SAMPLE_BITS-1:0] ir_sample;
        logic [BAR_BITS-1:0]    bar_height;
        logic                   bar_update;
        logic                   finger_present;
        logic                   block_end;
    } out_item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]  valid_low;
        logic [SAMPLE_BITS-1:0]  valid_high;
        logic [MARGIN_BITS-1:0]  peak_margin;
        logic [DIVISOR_BITS-1:0] range_divisor;
        logic [BAR_BITS-1:0]     bar_limit;
        logic [STROBE_BITS-1:0]  update_interval;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [TRACK_BITS-1:0] dividend;
        logic [TRACK_BITS-1:0] divisor;
    } div_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_BAR_GO,
        ST_BAR_WAIT,
        ST_PUSH,
        ST_RELOAD_GO,
        ST_RELOAD_WAIT
    } state_t;

endpackage

// ===== hdl/pwbs_cfg.sv =====
// Configuration register file for the waveform bar scaler.
`timescale 1ns / 1ps
module pwbs_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pwbs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pwbs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output pwbs_pkg::cfg_t                      cfg
);

    pwbs_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.valid_low       <= pwbs_pkg::VALID_LOW_RST;
            cfg_reg.valid_high      <= pwbs_pkg::VALID_HIGH_RST;
            cfg_reg.peak_margin     <= pwbs_pkg::PEAK_MARGIN_RST;
            cfg_reg.range_divisor   <= pwbs_pkg::RANGE_DIVISOR_RST;
            cfg_reg.bar_limit       <= pwbs_pkg::BAR_LIMIT_RST;
            cfg_reg.update_interval <= pwbs_pkg::UPDATE_INTERVAL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pwbs_pkg::REG_VALID_LOW:
                    cfg_reg.valid_low <= cfg_data[pwbs_pkg::SAMPLE_BITS-1:0];
                pwbs_pkg::REG_VALID_HIGH:
                    cfg_reg.valid_high <= cfg_data[pwbs_pkg::SAMPLE_BITS-1:0];
                pwbs_pkg::REG_PEAK_MARGIN:
                    cfg_reg.peak_margin <= cfg_data[pwbs_pkg::MARGIN_BITS-1:0];
                pwbs_pkg::REG_RANGE_DIVISOR:
                    cfg_reg.range_divisor <= cfg_data[pwbs_pkg::DIVISOR_BITS-1:0];
                pwbs_pkg::REG_BAR_LIMIT:
                    cfg_reg.bar_limit <= cfg_data[pwbs_pkg::BAR_BITS-1:0];
                pwbs_pkg::REG_UPDATE_INTERVAL:
                    cfg_reg.update_interval <= cfg_data[pwbs_pkg::STROBE_BITS-1:0];
                default:
                    ; // unmapped index, write dropped
            endcase
        end
    end

endmodule

// ===== hdl/pwbs_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module pwbs_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  pwbs_pkg::div_req_t              req,
    output logic                            done,
    output logic [pwbs_pkg::TRACK_BITS-1:0] quotient
);

    localparam int W = pwbs_pkg::TRACK_BITS;

    logic                               busy_reg;
    logic [pwbs_pkg::DIV_CNT_BITS-1:0]  cnt_reg;
    logic [W-1:0]                       rem_reg;
    logic [W-1:0]                       quo_reg;
    logic [W-1:0]                       divisor_reg;

    logic [W:0]   trial;
    logic [W:0]   trial_diff;
    logic         fits;
    logic [W-1:0] rem_next;

    // shift the next dividend bit into the partial remainder, subtract if it fits
    always_comb
    begin
        trial      = {rem_reg, quo_reg[W-1]};
        trial_diff = trial - {1'b0, divisor_reg};
        fits       = (trial >= {1'b0, divisor_reg});
        rem_next   = fits ? trial_diff[W-1:0] : trial[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= pwbs_pkg::DIV_CNT_BITS'(W);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg     <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            quo_reg <= {quo_reg[W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule

// ===== hdl/ppg_waveform_bar_scaler.sv =====
// Top level of the waveform bar scaler: sample tracking, sequencer and result register.
`timescale 1ns / 1ps
// Takes one raw optical sensor sample (three red and three infrared bytes per
// item), unpacks the low 18 bits of each, and returns one result item with both
// values, a bar height, a display strobe, a finger flag and an end-of-block flag.
// An infrared value strictly inside (valid_low, valid_high) above the running
// max sets it to ir + peak_margin; one below the running min sets it to
// ir - peak_margin (saturating at 0) and recomputes the scale step as
// (max - min) / range_divisor. The bar height is (max - ir) / step saturated at
// bar_limit; no finger gives 1 (still limited), a zero step gives 0. Every 100
// items the max and min are reloaded from the raw infrared extremes of items
// 1..99 of that block and the step is recomputed. All divisions share one
// bit-serial divider that loads, works out the 19 quotient bits and sets done.
// An item needs no division without a finger or with a zero step, else a bar
// division, after a step one if the min widens; a block end adds a reload.
// Input ready is high only while the sequencer is idle; the result sits in an
// output register, so a waiting result stalls the block only when the next
// result is ready to go. Config is a register write port that is always ready.
module ppg_waveform_bar_scaler
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pwbs_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pwbs_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pwbs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pwbs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int SB = pwbs_pkg::SAMPLE_BITS;
    localparam int TB = pwbs_pkg::TRACK_BITS;
    localparam int BB = pwbs_pkg::BAR_BITS;
    localparam int PB = pwbs_pkg::POS_BITS;

    pwbs_pkg::cfg_t     cfg_q;
    pwbs_pkg::div_req_t div_req;
    logic               div_done;
    logic [TB-1:0]      div_quo;

    pwbs_pkg::state_t   state_reg;
    pwbs_pkg::state_t   state_next;

    // tracking state
    logic [TB-1:0]                      track_max_reg;
    logic [TB-1:0]                      track_min_reg;
    logic [TB-1:0]                      step_reg;
    logic [SB-1:0]                      win_max_reg;
    logic [SB-1:0]                      win_min_reg;
    logic [pwbs_pkg::STROBE_BITS-1:0]   strobe_cnt_reg;
    logic [PB-1:0]                      pos_reg;

    // item in flight
    logic [SB-1:0] red_reg;
    logic [SB-1:0] ir_reg;
    logic [BB-1:0] bar_reg;
    logic          strobe_flag_reg;
    logic          finger_reg;
    logic          last_reg;

    // result register
    logic                out_valid_reg;
    pwbs_pkg::out_item_t out_data_reg;

    // sample decode
    logic                             accept;
    logic [SB-1:0]                    red_s;
    logic [SB-1:0]                    ir_s;
    logic [TB-1:0]                    ir_ext;
    logic                             finger;
    logic                             widen_max;
    logic                             widen_min;
    logic [TB-1:0]                    ir_max_new;
    logic [SB-1:0]                    margin_s;
    logic [SB-1:0]                    ir_min_new;
    logic [pwbs_pkg::STROBE_BITS-1:0] strobe_inc;
    logic                             strobe_hit;
    logic                             pos_last;

    // divider operands
    logic [TB-1:0] span;
    logic [TB-1:0] bar_diff;
    logic [TB-1:0] divisor_eff;

    // sequencer outputs
    logic out_free;
    logic push;
    logic div_go;
    logic sel_bar;

    function automatic logic [BB-1:0] clamp_bar(input logic [TB-1:0] raw,
                                                input logic [BB-1:0] lim);
        logic [BB-1:0] res;
        if (raw > TB'(lim))
            res = lim;
        else
            res = raw[BB-1:0];
        return res;
    endfunction

    pwbs_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg_q)
    );

    pwbs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---------------------------------------------------------------- decode
    always_comb
    begin
        accept     = in_valid && in_ready;
        red_s      = in_data.red_bytes[SB-1:0];
        ir_s       = in_data.ir_bytes[SB-1:0];
        ir_ext     = {1'b0, ir_s};
        finger     = (ir_s > cfg_q.valid_low) && (ir_s < cfg_q.valid_high);
        widen_max  = finger && (ir_ext > track_max_reg);
        widen_min  = finger && !widen_max && (ir_ext < track_min_reg);
        ir_max_new = ir_ext + TB'(cfg_q.peak_margin);
        margin_s   = SB'(cfg_q.peak_margin);
        ir_min_new = (ir_s > margin_s) ? (ir_s - margin_s) : '0;
        strobe_inc = strobe_cnt_reg + 1'b1;          // 4-bit wrap
        strobe_hit = (strobe_inc == cfg_q.update_interval);
        pos_last   = (pos_reg >= PB'(pwbs_pkg::BLOCK_SAMPLES - 1));
    end

    // ------------------------------------------------------ divider operands
    always_comb
    begin
        span        = (track_max_reg > track_min_reg) ? (track_max_reg - track_min_reg) : '0;
        bar_diff    = (track_max_reg > {1'b0, ir_reg}) ? (track_max_reg - {1'b0, ir_reg}) : '0;
        divisor_eff = (cfg_q.range_divisor == '0) ? TB'(1) : TB'(cfg_q.range_divisor);

        div_req.start    = div_go;
        div_req.dividend = sel_bar ? bar_diff : span;
        div_req.divisor  = sel_bar ? step_reg : divisor_eff;
    end

    // ------------------------------------------------------- sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pwbs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pwbs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (widen_min)
                        state_next = pwbs_pkg::ST_STEP_GO;
                    else if (finger && (step_reg != '0))
                        state_next = pwbs_pkg::ST_BAR_GO;
                    else
                        state_next = pwbs_pkg::ST_PUSH;
                end
            end
            pwbs_pkg::ST_STEP_GO:
                state_next = pwbs_pkg::ST_STEP_WAIT;
            pwbs_pkg::ST_STEP_WAIT:
            begin
                if (div_done)
                    state_next = (div_quo != '0) ? pwbs_pkg::ST_BAR_GO : pwbs_pkg::ST_PUSH;
            end
            pwbs_pkg::ST_BAR_GO:
                state_next = pwbs_pkg::ST_BAR_WAIT;
            pwbs_pkg::ST_BAR_WAIT:
            begin
                if (div_done)
                    state_next = pwbs_pkg::ST_PUSH;
            end
            pwbs_pkg::ST_PUSH:
            begin
                if (out_free)
                    state_next = last_reg ? pwbs_pkg::ST_RELOAD_GO : pwbs_pkg::ST_IDLE;
            end
            pwbs_pkg::ST_RELOAD_GO:
                state_next = pwbs_pkg::ST_RELOAD_WAIT;
            pwbs_pkg::ST_RELOAD_WAIT:
            begin
                if (div_done)
                    state_next = pwbs_pkg::ST_IDLE;
            end
            default:
                state_next = pwbs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        div_go   = 1'b0;
        sel_bar  = 1'b0;
        push     = 1'b0;
        case (state_reg)
            pwbs_pkg::ST_IDLE:
                in_ready = 1'b1;
            pwbs_pkg::ST_STEP_GO,
            pwbs_pkg::ST_RELOAD_GO:
                div_go = 1'b1;
            pwbs_pkg::ST_BAR_GO:
            begin
                div_go  = 1'b1;
                sel_bar = 1'b1;
            end
            pwbs_pkg::ST_BAR_WAIT:
                sel_bar = 1'b1;
            pwbs_pkg::ST_PUSH:
                push = out_free;
            default:
                ;
        endcase
    end

    // ------------------------------------------------------- tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_max_reg  <= '0;
            track_min_reg  <= '0;
            step_reg       <= '0;
            win_max_reg    <= '0;
            win_min_reg    <= pwbs_pkg::SAMPLE_MASK;
            strobe_cnt_reg <= '0;
            pos_reg        <= '0;
        end
        else if (accept)
        begin
            if (widen_max)
                track_max_reg <= ir_max_new;
            if (widen_min)
                track_min_reg <= {1'b0, ir_min_new};
            // first item of a block stays out of the next window
            if (pos_reg != '0)
            begin
                if (ir_s > win_max_reg)
                    win_max_reg <= ir_s;
                if (ir_s < win_min_reg)
                    win_min_reg <= ir_s;
            end
            strobe_cnt_reg <= strobe_hit ? '0 : strobe_inc;
            pos_reg        <= pos_last ? '0 : (pos_reg + 1'b1);
        end
        else if (push && last_reg)
        begin
            // block end: reload extremes, step follows in the reload division
            track_max_reg <= {1'b0, win_max_reg};
            track_min_reg <= {1'b0, win_min_reg};
            win_max_reg   <= '0;
            win_min_reg   <= pwbs_pkg::SAMPLE_MASK;
        end
        else if (div_done && ((state_reg == pwbs_pkg::ST_STEP_WAIT) ||
                              (state_reg == pwbs_pkg::ST_RELOAD_WAIT)))
        begin
            step_reg <= div_quo;
        end
    end

    // -------------------------------------------------------- item in flight
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg         <= red_s;
            ir_reg          <= ir_s;
            finger_reg      <= finger;
            strobe_flag_reg <= strobe_hit;
            last_reg        <= pos_last;
            // no finger shows a stub bar of 1; finger with zero step shows 0
            bar_reg         <= clamp_bar(finger ? TB'(0) : TB'(1), cfg_q.bar_limit);
        end
        else if (div_done && (state_reg == pwbs_pkg::ST_BAR_WAIT))
        begin
            bar_reg <= clamp_bar(div_quo, cfg_q.bar_limit);
        end
    end

    // ------------------------------------------------------- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (push)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_data_reg.red_sample     <= red_reg;
            out_data_reg.ir_sample      <= ir_reg;
            out_data_reg.bar_height     <= bar_reg;
            out_data_reg.bar_update     <= strobe_flag_reg;
            out_data_reg.finger_present <= finger_reg;
            out_data_reg.block_end      <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------ assertions
    a_accept_leaves_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != pwbs_pkg::ST_IDLE))
        else $error("sequencer stayed idle after taking an item");

    a_push_sets_valid : assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid_reg)
        else $error("result register not loaded on push");

    a_done_in_wait : assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == pwbs_pkg::ST_STEP_WAIT) ||
                      (state_reg == pwbs_pkg::ST_BAR_WAIT) ||
                      (state_reg == pwbs_pkg::ST_RELOAD_WAIT)))
        else $error("divider finished outside a wait state");

    a_bar_limited : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.bar_height <= cfg_q.bar_limit))
        else $error("bar height above limit");

    a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < PB'(pwbs_pkg::BLOCK_SAMPLES))
        else $error("block position out of range");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the waveform bar scaler: random samples, settings and stalls.
`timescale 1ns / 1ps

// Tracks the running max/min, scale step, block window and strobe counter
// alongside the block, and keeps the result items still owed in order.
class bar_tracker;
    pwbs_pkg::cfg_t                   regs;
    logic [pwbs_pkg::POS_BITS-1:0]    block_pos;
    logic [pwbs_pkg::TRACK_BITS-1:0]  peak_hi;
    logic [pwbs_pkg::TRACK_BITS-1:0]  peak_lo;
    logic [pwbs_pkg::TRACK_BITS-1:0]  step_size;
    logic [pwbs_pkg::SAMPLE_BITS-1:0] win_hi;
    logic [pwbs_pkg::SAMPLE_BITS-1:0] win_lo;
    logic [pwbs_pkg::STROBE_BITS-1:0] strobe_cnt;
    pwbs_pkg::out_item_t              owed_results[$];
    int unsigned                      mismatches;

    function new();
        regs.valid_low       = pwbs_pkg::VALID_LOW_RST;
        regs.valid_high      = pwbs_pkg::VALID_HIGH_RST;
        regs.peak_margin     = pwbs_pkg::PEAK_MARGIN_RST;
        regs.range_divisor   = pwbs_pkg::RANGE_DIVISOR_RST;
        regs.bar_limit       = pwbs_pkg::BAR_LIMIT_RST;
        regs.update_interval = pwbs_pkg::UPDATE_INTERVAL_RST;
        block_pos   = '0;
        peak_hi     = '0;
        peak_lo     = '0;
        step_size   = '0;
        win_hi      = '0;
        win_lo      = pwbs_pkg::SAMPLE_MASK;
        strobe_cnt  = '0;
        mismatches  = 0;
    endfunction

    function void set_register(logic [pwbs_pkg::CFG_INDEX_BITS-1:0] index,
                               logic [pwbs_pkg::CFG_DATA_BITS-1:0] value);
        case (index)
            pwbs_pkg::REG_VALID_LOW:
                regs.valid_low       = value;
            pwbs_pkg::REG_VALID_HIGH:
                regs.valid_high      = value;
            pwbs_pkg::REG_PEAK_MARGIN:
                regs.peak_margin     = value[pwbs_pkg::MARGIN_BITS-1:0];
            pwbs_pkg::REG_RANGE_DIVISOR:
                regs.range_divisor   = value[pwbs_pkg::DIVISOR_BITS-1:0];
            pwbs_pkg::REG_BAR_LIMIT:
                regs.bar_limit       = value[pwbs_pkg::BAR_BITS-1:0];
            pwbs_pkg::REG_UPDATE_INTERVAL:
                regs.update_interval = value[pwbs_pkg::STROBE_BITS-1:0];
            default: ;
        endcase
    endfunction

    // (hi - lo) / divisor, with a zero divisor read as 1 and a negative span as 0
    function logic [pwbs_pkg::TRACK_BITS-1:0] span_step(
        logic [pwbs_pkg::TRACK_BITS-1:0] hi,
        logic [pwbs_pkg::TRACK_BITS-1:0] lo);
        logic [pwbs_pkg::TRACK_BITS-1:0]   span;
        logic [pwbs_pkg::DIVISOR_BITS-1:0] div;
        div  = (regs.range_divisor == '0) ? pwbs_pkg::DIVISOR_BITS'(1) : regs.range_divisor;
        span = (hi > lo) ? hi - lo : '0;
        return span / div;
    endfunction

    function void take_sample(pwbs_pkg::in_item_t item);
        logic [pwbs_pkg::SAMPLE_BITS-1:0] red;
        logic [pwbs_pkg::SAMPLE_BITS-1:0] ir;
        logic                             finger;
        logic                             strobe;
        logic                             last;
        int unsigned                      bar;
        int unsigned                      diff;
        pwbs_pkg::out_item_t              res;
        red    = item.red_bytes[pwbs_pkg::SAMPLE_BITS-1:0];
        ir     = item.ir_bytes[pwbs_pkg::SAMPLE_BITS-1:0];
        finger = (ir > regs.valid_low) && (ir < regs.valid_high);
        if (finger)
        begin
            if (ir > peak_hi)
                peak_hi = ir + regs.peak_margin;
            else if (ir < peak_lo)
            begin
                peak_lo   = (ir > regs.peak_margin) ? ir - regs.peak_margin : '0;
                step_size = span_step(peak_hi, peak_lo);
            end
            if (step_size == '0)
                bar = 0;
            else
            begin
                diff = (peak_hi > ir) ? peak_hi - ir : 0;
                bar  = diff / step_size;
            end
        end
        else
            bar = 1;
        if (bar > regs.bar_limit)
            bar = regs.bar_limit;

        strobe_cnt = strobe_cnt + 1'b1;
        strobe     = (strobe_cnt == regs.update_interval);
        if (strobe)
            strobe_cnt = '0;

        // position 0 of a block stays out of the next window
        if (block_pos != '0)
        begin
            if (ir > win_hi) win_hi = ir;
            if (ir < win_lo) win_lo = ir;
        end

        last = (block_pos >= pwbs_pkg::POS_BITS'(pwbs_pkg::BLOCK_SAMPLES - 1));
        if (last)
        begin
            peak_hi   = win_hi;
            peak_lo   = win_lo;
            step_size = span_step(peak_hi, peak_lo);
            win_hi    = '0;
            win_lo    = pwbs_pkg::SAMPLE_MASK;
            block_pos = '0;
        end
        else
            block_pos = block_pos + 1'b1;

        res.red_sample     = red;
        res.ir_sample      = ir;
        res.bar_height     = bar[pwbs_pkg::BAR_BITS-1:0];
        res.bar_update     = strobe;
        res.finger_present = finger;
        res.block_end      = last;
        owed_results.push_back(res);
    endfunction

    function int pending();
        return owed_results.size();
    endfunction

    task report(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task match_result(pwbs_pkg::out_item_t got);
        pwbs_pkg::out_item_t want;
        if (owed_results.size() == 0)
        begin
            report($sformatf("result item with none owed: %h", got));
            return;
        end
        want = owed_results.pop_front();
        if (got.red_sample !== want.red_sample)
            report($sformatf("red_sample %h, want %h", got.red_sample, want.red_sample));
        if (got.ir_sample !== want.ir_sample)
            report($sformatf("ir_sample %h, want %h", got.ir_sample, want.ir_sample));
        if (got.bar_height !== want.bar_height)
            report($sformatf("bar_height %0d, want %0d (ir %h)",
                             got.bar_height, want.bar_height, want.ir_sample));
        if (got.bar_update !== want.bar_update)
            report($sformatf("bar_update %b, want %b", got.bar_update, want.bar_update));
        if (got.finger_present !== want.finger_present)
            report($sformatf("finger_present %b, want %b (ir %h)",
                             got.finger_present, want.finger_present, want.ir_sample));
        if (got.block_end !== want.block_end)
            report($sformatf("block_end %b, want %b", got.block_end, want.block_end));
    endtask
endclass

module tb_top;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    pwbs_pkg::in_item_t                  in_data;
    logic                                out_valid;
    logic                                out_ready;
    pwbs_pkg::out_item_t                 out_data;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [pwbs_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [pwbs_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    bar_tracker tracker = new();

    // position of the slowly wandering infrared trace inside the window
    int walk_ir;
    // remaining items of a back-to-back stretch on the sample side
    int burst_left;

    ppg_waveform_bar_scaler dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit. Covers about 2000 items even if each meets the slowest sender gap,
    // block path and receiver stall at once, and still leaves a wide margin.
    initial
    begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    // All handshakes are sampled here at the rising edge; stimulus moves on
    // the falling edge, so nothing depends on event order within a step.
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            tracker.set_register(cfg_index, cfg_data);
        if (rst_n && in_valid && in_ready)
            tracker.take_sample(in_data);
        if (rst_n && out_valid && out_ready)
            tracker.match_result(out_data);
    end

    // Result side back-pressure: mostly short ready/stall runs, some long
    // stalls, and long stretches of steady ready.
    initial
    begin
        int  hold;
        int  r;
        logic rdy;
        out_ready = 1'b0;
        hold      = 0;
        rdy       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    rdy  = 1'b1;
                    hold = $urandom_range(1, 12);
                end
                else if (r < 65)
                begin
                    rdy  = 1'b1;
                    hold = $urandom_range(100, 300);
                end
                else if (r < 93)
                begin
                    rdy  = 1'b0;
                    hold = $urandom_range(1, 3);
                end
                else
                begin
                    rdy  = 1'b0;
                    hold = $urandom_range(10, 40);
                end
            end
            out_ready = rdy;
            hold--;
        end
    end

    // Idle cycles before the next sample: usually none or a few, now and
    // then a long pause, and occasional back-to-back stretches.
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with in_valid still high, so a following item can go out without a gap.
    task automatic send_sample(pwbs_pkg::in_item_t item);
        in_valid = 1'b1;
        in_data  = item;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic idle_input(int cycles);
        if (cycles > 0)
        begin
            in_valid = 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic write_register(logic [pwbs_pkg::CFG_INDEX_BITS-1:0] index,
                                  logic [pwbs_pkg::CFG_DATA_BITS-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(pwbs_pkg::cfg_t c);
        write_register(pwbs_pkg::REG_VALID_LOW,  c.valid_low);
        write_register(pwbs_pkg::REG_VALID_HIGH, c.valid_high);
        write_register(pwbs_pkg::REG_PEAK_MARGIN,
                       pwbs_pkg::CFG_DATA_BITS'(c.peak_margin));
        write_register(pwbs_pkg::REG_RANGE_DIVISOR,
                       pwbs_pkg::CFG_DATA_BITS'(c.range_divisor));
        write_register(pwbs_pkg::REG_BAR_LIMIT,
                       pwbs_pkg::CFG_DATA_BITS'(c.bar_limit));
        write_register(pwbs_pkg::REG_UPDATE_INTERVAL,
                       pwbs_pkg::CFG_DATA_BITS'(c.update_interval));
    endtask

    // Every item yields one result; once nothing is owed and the input is
    // ready again (block-end reload finished) the block is idle.
    task automatic drain();
        in_valid = 1'b0;
        while ((tracker.pending() != 0) || !in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic int clamp_sample(int v);
        if (v < 0) return 0;
        if (v > int'(pwbs_pkg::SAMPLE_MASK)) return int'(pwbs_pkg::SAMPLE_MASK);
        return v;
    endfunction

    // Infrared value for the next item. Most follow a random walk inside the
    // finger window so the max/min tracking, step updates and block reloads
    // all get exercised; the rest are full-range noise, window edges, and
    // values near 0 (min saturation) or near full scale.
    function automatic logic [pwbs_pkg::SAMPLE_BITS-1:0] next_ir(pwbs_pkg::cfg_t c);
        int lo_in;
        int hi_in;
        int amp;
        int r;
        int v;
        lo_in = int'(c.valid_low) + 1;
        hi_in = int'(c.valid_high) - 1;
        r     = $urandom_range(0, 99);
        if (r < 70 && hi_in > lo_in)
        begin
            amp     = (hi_in - lo_in) / 24 + 1;
            walk_ir = walk_ir + int'($urandom_range(0, 2 * amp)) - amp;
            if (walk_ir < lo_in) walk_ir = lo_in;
            if (walk_ir > hi_in) walk_ir = hi_in;
            v = walk_ir;
        end
        else if (r < 85)
            v = $urandom_range(0, int'(pwbs_pkg::SAMPLE_MASK));
        else if (r < 95)
        begin
            case ($urandom_range(0, 3))
                0:       v = int'(c.valid_low);
                1:       v = lo_in + int'($urandom_range(0, 3));
                2:       v = int'(c.valid_high);
                default: v = hi_in - int'($urandom_range(0, 3));
            endcase
        end
        else if ($urandom_range(0, 1) == 0)
            v = $urandom_range(0, 4095);
        else
            v = int'(pwbs_pkg::SAMPLE_MASK) - int'($urandom_range(0, 15));
        v = clamp_sample(v);
        return v[pwbs_pkg::SAMPLE_BITS-1:0];
    endfunction

    function automatic pwbs_pkg::cfg_t random_settings();
        pwbs_pkg::cfg_t c;
        int             lo;
        lo = $urandom_range(0, 240000);
        c.valid_low  = pwbs_pkg::SAMPLE_BITS'(lo);
        c.valid_high = pwbs_pkg::SAMPLE_BITS'(
            lo + int'($urandom_range(2, int'(pwbs_pkg::SAMPLE_MASK) - lo)));
        c.peak_margin = ($urandom_range(0, 3) == 0) ?
                        pwbs_pkg::MARGIN_BITS'($urandom) :
                        pwbs_pkg::MARGIN_BITS'($urandom_range(0, 600));
        c.range_divisor = ($urandom_range(0, 3) == 0) ?
                          pwbs_pkg::DIVISOR_BITS'($urandom_range(1, 255)) :
                          pwbs_pkg::DIVISOR_BITS'($urandom_range(1, 24));
        c.bar_limit       = pwbs_pkg::BAR_BITS'($urandom_range(1, 63));
        c.update_interval = pwbs_pkg::STROBE_BITS'($urandom_range(1, 15));
        return c;
    endfunction

    // One settings phase: drain, rewrite every register, then a run of samples.
    task automatic run_phase(pwbs_pkg::cfg_t c, int count);
        pwbs_pkg::in_item_t item;
        drain();
        apply_settings(c);
        walk_ir = (int'(c.valid_low) + int'(c.valid_high)) / 2;
        for (int i = 0; i < count; i++)
        begin
            item.red_bytes = pwbs_pkg::BYTES_BITS'($urandom);
            item.ir_bytes  = {6'($urandom), next_ir(c)};
            send_sample(item);
            idle_input(pick_gap());
        end
    endtask

    // Hand-picked samples under the reset settings: field extremes, the
    // window edges (both exclusive), a first finger sample with a zero step,
    // a widening max, and a finger sample below max while the step is zero.
    task automatic run_directed();
        pwbs_pkg::in_item_t               items[$];
        logic [pwbs_pkg::SAMPLE_BITS-1:0] vl;
        logic [pwbs_pkg::SAMPLE_BITS-1:0] vh;
        vl = pwbs_pkg::VALID_LOW_RST;
        vh = pwbs_pkg::VALID_HIGH_RST;
        items.push_back('{24'h000000, 24'h000000});
        items.push_back('{24'hFFFFFF, 24'hFFFFFF});
        items.push_back('{24'hFC0000, 24'hFC0000});
        items.push_back('{24'h03FFFF, {6'h15, vl}});
        items.push_back('{24'h555555, {6'h2A, vl + 1'b1}});
        items.push_back('{24'hAAAAAA, {6'h00, vh - 1'b1}});
        items.push_back('{24'h123456, {6'h3F, vh}});
        items.push_back('{24'hABCDEF, {6'h00, 18'd150000}});
        items.push_back('{24'h000001, {6'h00, vh + 1'b1}});
        items.push_back('{24'h800000, {6'h01, 18'd100000}});
        items.push_back('{24'h7FFFFF, {6'h20, 18'd90000}});
        items.push_back('{24'h00FF00, {6'h3F, 18'd196000}});
        items.push_back('{24'hFEDCBA, {6'h0F, 18'd1}});
        items.push_back('{24'h3C3C3C, {6'h30, 18'd120000}});
        foreach (items[i])
        begin
            send_sample(items[i]);
            idle_input(pick_gap());
        end
    endtask

    initial
    begin
        pwbs_pkg::cfg_t c;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = pwbs_pkg::REG_VALID_LOW;
        cfg_data   = '0;
        walk_ir    = 0;
        burst_left = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        // wide-open window, no margin, finest step, tallest bar, strobe every item
        c = '{valid_low: '0, valid_high: pwbs_pkg::SAMPLE_MASK, peak_margin: '0,
              range_divisor: 8'd1, bar_limit: 6'd63, update_interval: 4'd1};
        run_phase(c, 230);

        // widest margin (min saturates at 0), coarsest step, bar limit of 1
        c = '{valid_low: '0, valid_high: pwbs_pkg::SAMPLE_MASK, peak_margin: 12'hFFF,
              range_divisor: 8'd255, bar_limit: 6'd1, update_interval: 4'd15};
        run_phase(c, 230);

        // zero divisor acts as 1, zero interval lets the strobe counter wrap
        c = '{valid_low: pwbs_pkg::VALID_LOW_RST, valid_high: pwbs_pkg::VALID_HIGH_RST,
              peak_margin: pwbs_pkg::PEAK_MARGIN_RST, range_divisor: 8'd0,
              bar_limit: pwbs_pkg::BAR_LIMIT_RST, update_interval: 4'd0};
        run_phase(c, 230);

        // empty window: no finger anywhere, bar stays at 1
        c = '{valid_low: pwbs_pkg::SAMPLE_MASK, valid_high: '0, peak_margin: 12'd77,
              range_divisor: 8'd9, bar_limit: 6'd63, update_interval: 4'd7};
        run_phase(c, 120);

        for (int p = 0; p < 5; p++)
            run_phase(random_settings(), 230);

        drain();
        repeat (70) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d result items never arrived", tracker.pending()));
        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
